### src/twsm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the three-way sorted merge
// no dependencies; every other file in src uses it by scoped names

package twsm_pkg;

    localparam int unsigned KEY_W      = 64;
    localparam int unsigned VER_W      = 64;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CAP_W      = 32;
    localparam int unsigned TOTAL_W    = 32;

    // defaults for the top level parameters
    localparam int unsigned COUNT_BITS_DEF = 32;
    localparam int unsigned SUM_BITS_DEF   = 32;

    // depth of the queue between classifier and commit stage
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = '1;

    // head status codes; code three reads as a deleted head
    localparam logic [STATUS_W-1:0] STATUS_ABSENT  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LIVE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DELETED = 2'd2;

    typedef enum logic [1:0] {
        PICK_BASE,
        PICK_OURS,
        PICK_THEIRS
    } pick_t;

    typedef struct packed {
        logic [KEY_W-1:0]    base_key;
        logic [STATUS_W-1:0] base_status;
        logic [SUM_W-1:0]    base_sum;
        logic [VER_W-1:0]    base_version;
        logic [KEY_W-1:0]    ours_key;
        logic [STATUS_W-1:0] ours_status;
        logic [SUM_W-1:0]    ours_sum;
        logic [VER_W-1:0]    ours_version;
        logic [KEY_W-1:0]    theirs_key;
        logic [STATUS_W-1:0] theirs_status;
        logic [SUM_W-1:0]    theirs_sum;
        logic [VER_W-1:0]    theirs_version;
    } in_item_t;

    typedef struct packed {
        logic                emit_valid;
        logic [KEY_W-1:0]    merged_key;
        logic [SUM_W-1:0]    merged_sum;
        logic                merged_deleted;
        logic [VER_W-1:0]    merged_version;
        logic                advance_base;
        logic                advance_ours;
        logic                advance_theirs;
        logic                conflict_here;
        logic [TOTAL_W-1:0]  merged_total;
        logic [TOTAL_W-1:0]  conflict_total;
        logic                overflow;
    } out_item_t;

    // classified merge step, before capacity and counters are applied
    typedef struct packed {
        logic             emit;
        logic             conflict;
        logic             adv_base;
        logic             adv_ours;
        logic             adv_theirs;
        logic [KEY_W-1:0] key;
        logic [SUM_W-1:0] sum;
        logic             deleted;
        logic [VER_W-1:0] version;
    } entry_t;

endpackage

### src/three_way_sorted_merge.sv
`timescale 1ns / 1ps
// top level of the three-way merge of key-sorted streams
// depends on twsm_pkg, twsm_front, twsm_queue and twsm_back
//
//   channel    valid / stall               payload                  direction
//   heads      head_valid / head_stall     heads (in_item_t)        in
//   results    merge_valid / merge_stall   merge_result (out_item_t) out
//   capacity   capacity_we                 capacity_wdata           in, write only
//
// one merge step per cycle sustained while merge_stall is low; an item is written
// into the queue at its transfer, then the commit stage loads it into the result
// reg, where it stays valid until it transfers out
// the commit stage's counter update sets the one-step-per-cycle rate
// reset: capacity all ones, counters and overflow cleared, queue and result reg empty
// head_stall is high while the two-entry queue is full; merge_stall holds the
// result reg and backs the queue up without losing an entry

module three_way_sorted_merge #(
    parameter int unsigned COUNT_BITS = twsm_pkg::COUNT_BITS_DEF,
    parameter int unsigned SUM_BITS   = twsm_pkg::SUM_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // stream heads
    input  logic                       head_valid,
    output logic                       head_stall,
    input  twsm_pkg::in_item_t         heads,
    // merged results
    output logic                       merge_valid,
    input  logic                       merge_stall,
    output twsm_pkg::out_item_t        merge_result,
    // capacity register, to be written only while idle; the block does not enforce this
    input  logic                       capacity_we,
    input  logic [twsm_pkg::CAP_W-1:0] capacity_wdata
);

    twsm_pkg::entry_t front_entry;
    twsm_pkg::entry_t q_entry;
    logic             q_full;
    logic             q_filled;
    logic             q_pop;
    logic             head_xfer;

    // classify combinationally; the queue write is the front stage register
    twsm_front #(
        .SUM_BITS (SUM_BITS)
    ) u_front (
        .heads (heads),
        .entry (front_entry)
    );

    // stall depends on queue occupancy only, never on head_valid
    assign head_stall = q_full;
    assign head_xfer  = head_valid && !head_stall;

    twsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (head_xfer),
        .push_entry (front_entry),
        .full       (q_full),
        .filled     (q_filled),
        .pop        (q_pop),
        .head_entry (q_entry)
    );

    // commit stage owns all state that links one step to the next
    twsm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .q_filled       (q_filled),
        .q_entry        (q_entry),
        .q_pop          (q_pop),
        .result_valid   (merge_valid),
        .result_stall   (merge_stall),
        .result         (merge_result)
    );

    // once overflow is reported, that result carries no entry
    a_overflow_no_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (merge_valid && merge_result.overflow) |-> !merge_result.emit_valid
    ) else $error("result emits an entry while overflow is set");

    // an emitted entry always comes from at least one head that advances
    a_emit_advances: assert property (
        @(posedge clk) disable iff (!rst_n)
        (merge_valid && merge_result.emit_valid) |->
            (merge_result.advance_base || merge_result.advance_ours ||
             merge_result.advance_theirs)
    ) else $error("emitted entry with no advancing head");

    // a successful emit is checked to have been counted; an emit popped during a capacity write is not
    a_emit_counted: assert property (
        @(posedge clk) disable iff (!rst_n)
        (merge_valid && merge_result.emit_valid) |-> (merge_result.merged_total != '0)
    ) else $error("emitted entry with zero total");

    // a pop only happens with an entry waiting in the queue
    a_pop_filled: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> q_filled
    ) else $error("queue popped while empty");

endmodule

### src/twsm_front.sv
`timescale 1ns / 1ps
// classifier: least key among present heads and the three-way merge rule
// depends on twsm_pkg

module twsm_front #(
    parameter int unsigned SUM_BITS = twsm_pkg::SUM_BITS_DEF
) (
    input  twsm_pkg::in_item_t heads,
    output twsm_pkg::entry_t   entry
);

    localparam int unsigned SUM_KEEP = (SUM_BITS < twsm_pkg::SUM_W) ? SUM_BITS : twsm_pkg::SUM_W;
    localparam logic [twsm_pkg::SUM_W-1:0] SUM_MASK =
        {twsm_pkg::SUM_W{1'b1}} >> (twsm_pkg::SUM_W - SUM_KEEP);

    logic pb, po, pt;
    logic db, dd_o, dt;
    logic [twsm_pkg::SUM_W-1:0] sb, so, st;
    logic o_lt_b, t_lt_b, b_lt_o, t_lt_o, b_lt_t, o_lt_t;
    logic hb, ho, ht;
    logic same_ot, same_ob, same_tb;
    logic o_newer;
    logic emit, conflict;
    twsm_pkg::pick_t pick;

    assign pb = (heads.base_status != twsm_pkg::STATUS_ABSENT);
    assign po = (heads.ours_status != twsm_pkg::STATUS_ABSENT);
    assign pt = (heads.theirs_status != twsm_pkg::STATUS_ABSENT);

    assign db   = heads.base_status[1];
    assign dd_o = heads.ours_status[1];
    assign dt   = heads.theirs_status[1];

    assign sb = heads.base_sum & SUM_MASK;
    assign so = heads.ours_sum & SUM_MASK;
    assign st = heads.theirs_sum & SUM_MASK;

    // pairwise key compares run side by side
    assign o_lt_b = heads.ours_key < heads.base_key;
    assign t_lt_b = heads.theirs_key < heads.base_key;
    assign b_lt_o = heads.base_key < heads.ours_key;
    assign t_lt_o = heads.theirs_key < heads.ours_key;
    assign b_lt_t = heads.base_key < heads.theirs_key;
    assign o_lt_t = heads.ours_key < heads.theirs_key;

    // a head holds the least key when no other present head is below it
    assign hb = pb && !(po && o_lt_b) && !(pt && t_lt_b);
    assign ho = po && !(pb && b_lt_o) && !(pt && t_lt_o);
    assign ht = pt && !(pb && b_lt_t) && !(po && o_lt_t);

    assign same_ot = (so == st) && (dd_o == dt);
    assign same_ob = (so == sb) && (dd_o == db);
    assign same_tb = (st == sb) && (dt == db);
    assign o_newer = heads.ours_version > heads.theirs_version;

    always_comb
    begin
        emit     = 1'b0;
        conflict = 1'b0;
        pick     = twsm_pkg::PICK_BASE;
        case ({hb, ho, ht})
            3'b011:
            begin
                emit = 1'b1;
                if (same_ot)
                begin
                    pick = twsm_pkg::PICK_OURS;
                end
                else
                begin
                    conflict = 1'b1;
                    pick = o_newer ? twsm_pkg::PICK_OURS : twsm_pkg::PICK_THEIRS;
                end
            end
            3'b010:
            begin
                emit = 1'b1;
                pick = twsm_pkg::PICK_OURS;
            end
            3'b001:
            begin
                emit = 1'b1;
                pick = twsm_pkg::PICK_THEIRS;
            end
            3'b111:
            begin
                emit = 1'b1;
                if (same_ob && same_tb)
                begin
                    pick = twsm_pkg::PICK_BASE;
                end
                else if (!same_ob && same_tb)
                begin
                    pick = twsm_pkg::PICK_OURS;
                end
                else if (same_ob && !same_tb)
                begin
                    pick = twsm_pkg::PICK_THEIRS;
                end
                else if (same_ot)
                begin
                    pick = twsm_pkg::PICK_OURS;
                end
                else
                begin
                    conflict = 1'b1;
                    pick = o_newer ? twsm_pkg::PICK_OURS : twsm_pkg::PICK_THEIRS;
                end
            end
            3'b110:
            begin
                // ours changed against a removal on theirs
                if (!same_ob)
                begin
                    emit     = 1'b1;
                    conflict = 1'b1;
                    pick     = twsm_pkg::PICK_OURS;
                end
            end
            3'b101:
            begin
                if (!same_tb)
                begin
                    emit     = 1'b1;
                    conflict = 1'b1;
                    pick     = twsm_pkg::PICK_THEIRS;
                end
            end
            default:
            begin
                emit     = 1'b0;
                conflict = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        entry.emit       = emit;
        entry.conflict   = conflict;
        entry.adv_base   = hb;
        entry.adv_ours   = ho;
        entry.adv_theirs = ht;
        case (pick)
            twsm_pkg::PICK_OURS:
            begin
                entry.key     = heads.ours_key;
                entry.sum     = so;
                entry.deleted = dd_o;
                entry.version = heads.ours_version;
            end
            twsm_pkg::PICK_THEIRS:
            begin
                entry.key     = heads.theirs_key;
                entry.sum     = st;
                entry.deleted = dt;
                entry.version = heads.theirs_version;
            end
            default:
            begin
                entry.key     = heads.base_key;
                entry.sum     = sb;
                entry.deleted = db;
                entry.version = heads.base_version;
            end
        endcase
    end

endmodule

### src/twsm_queue.sv
`timescale 1ns / 1ps
// short queue of classified entries between classifier and commit stage
// depends on twsm_pkg

module twsm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  twsm_pkg::entry_t push_entry,
    output logic             full,
    output logic             filled,
    input  logic             pop,
    output twsm_pkg::entry_t head_entry
);

    localparam int unsigned DEPTH = twsm_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    twsm_pkg::entry_t store [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign filled     = (count_reg != '0);
    assign head_entry = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/twsm_back.sv
`timescale 1ns / 1ps
// commit stage: capacity check, counters, sticky overflow and result register
// depends on twsm_pkg

module twsm_back #(
    parameter int unsigned COUNT_BITS = twsm_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          capacity_we,
    input  logic [twsm_pkg::CAP_W-1:0]    capacity_wdata,
    input  logic                          q_filled,
    input  twsm_pkg::entry_t              q_entry,
    output logic                          q_pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output twsm_pkg::out_item_t           result
);

    localparam int unsigned CMP_W =
        (COUNT_BITS > twsm_pkg::CAP_W) ? COUNT_BITS : twsm_pkg::CAP_W;

    logic [twsm_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic [COUNT_BITS-1:0]      emitted_reg, emitted_next;
    logic [COUNT_BITS-1:0]      conflict_reg, conflict_next;
    logic                       overflow_reg, overflow_next;
    logic                       valid_reg, valid_next;
    twsm_pkg::out_item_t        result_reg, result_next;

    logic [CMP_W-1:0] emitted_wide, capacity_wide;
    logic [CMP_W-1:0] emitted_new_wide, conflict_new_wide;
    logic             emit, conflict;

    assign q_pop        = q_filled && (!valid_reg || !result_stall);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        emitted_wide = '0;
        emitted_wide[COUNT_BITS-1:0] = emitted_reg;
        capacity_wide = '0;
        capacity_wide[twsm_pkg::CAP_W-1:0] = capacity_reg;
    end

    always_comb
    begin
        capacity_next = capacity_reg;
        emitted_next  = emitted_reg;
        conflict_next = conflict_reg;
        overflow_next = overflow_reg;
        emit          = q_entry.emit && !overflow_reg;
        conflict      = q_entry.conflict && !overflow_reg;
        if (capacity_we)
        begin
            capacity_next = capacity_wdata;
            emitted_next  = '0;
            conflict_next = '0;
            overflow_next = 1'b0;
        end
        else if (q_pop)
        begin
            if (conflict && (conflict_reg != {COUNT_BITS{1'b1}}))
            begin
                conflict_next = conflict_reg + 1'b1;
            end
            if (emit)
            begin
                if (emitted_wide >= capacity_wide)
                begin
                    overflow_next = 1'b1;
                    emit = 1'b0;
                end
                else if (emitted_reg != {COUNT_BITS{1'b1}})
                begin
                    emitted_next = emitted_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        emitted_new_wide = '0;
        emitted_new_wide[COUNT_BITS-1:0] = emitted_next;
        conflict_new_wide = '0;
        conflict_new_wide[COUNT_BITS-1:0] = conflict_next;

        result_next                = result_reg;
        result_next.emit_valid     = emit;
        result_next.merged_key     = emit ? q_entry.key : '0;
        result_next.merged_sum     = emit ? q_entry.sum : '0;
        result_next.merged_deleted = emit && q_entry.deleted;
        result_next.merged_version = emit ? q_entry.version : '0;
        result_next.advance_base   = q_entry.adv_base;
        result_next.advance_ours   = q_entry.adv_ours;
        result_next.advance_theirs = q_entry.adv_theirs;
        result_next.conflict_here  = conflict;
        result_next.merged_total   = emitted_new_wide[twsm_pkg::TOTAL_W-1:0];
        result_next.conflict_total = conflict_new_wide[twsm_pkg::TOTAL_W-1:0];
        result_next.overflow       = overflow_next;

        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= twsm_pkg::CAP_RESET;
            emitted_reg  <= '0;
            conflict_reg <= '0;
            overflow_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            emitted_reg  <= emitted_next;
            conflict_reg <= conflict_next;
            overflow_reg <= overflow_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule
